// File: sv/mmd_pkg.sv
// Package for the multichannel min/max peak decimator.
// Request and response payload types, register indexes and control struct.
// No dependencies.
package mmd_pkg;

   // Sample width and default sizing
   localparam int SAMPLE_BITS      = 16;
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int CHAN_FIELD_BITS  = 3;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CHAN_CNT_BITS  = 4;
   localparam int CHUNK_BITS     = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHUNK_FRAMES  = 2'd1;

   localparam logic [CHAN_CNT_BITS-1:0] CHAN_CNT_RESET = 4'd2;
   localparam logic [CHUNK_BITS-1:0]    CHUNK_RESET    = 16'd256;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value_low;
      logic signed [SAMPLE_BITS-1:0] value_high;
      logic                          end_of_stream;
   } req_type;

   typedef struct packed {
      logic [CHAN_FIELD_BITS-1:0]    channel;
      logic signed [SAMPLE_BITS-1:0] peak_min;
      logic signed [SAMPLE_BITS-1:0] peak_max;
      logic                          last_channel;
   } rsp_type;

   // Commands broadcast to every cell of the chain
   typedef struct packed {
      logic clear;
      logic shift;
      logic update;
   } cell_ctrl_type;

endpackage

// File: sv/mmd_cell.sv
// One accumulator cell of the decimator chain: running min and max of one channel.
// Depends on mmd_pkg. On a flush it takes its neighbour's values.
module mmd_cell
   import mmd_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctrl_type                 ctrl,
   input  logic                          sel,
   input  logic signed [SAMPLE_BITS-1:0] value_low,
   input  logic signed [SAMPLE_BITS-1:0] value_high,
   input  logic signed [SAMPLE_BITS-1:0] next_min,
   input  logic signed [SAMPLE_BITS-1:0] next_max,
   output logic signed [SAMPLE_BITS-1:0] cur_min,
   output logic signed [SAMPLE_BITS-1:0] cur_max
);

   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;

   // Clear wins, then shift along the chain, then fold in a new value
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (ctrl.clear) begin
         min_in = '0;
         max_in = '0;
      end else if (ctrl.shift) begin
         min_in = next_min;
         max_in = next_max;
      end else if (ctrl.update && sel) begin
         if (value_low < min_ff) begin
            min_in = value_low;
         end
         if (value_high > max_ff) begin
            max_in = value_high;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign cur_min = min_ff;
   assign cur_max = max_ff;

endmodule

// File: sv/multichannel_minmax_decimator_top.sv
// Top level of the multichannel min/max peak decimator.
// Depends on mmd_pkg and mmd_cell (one cell per channel, chained).
//
// A request is taken while the block is idle and folded into its channel's cell.
// When it closes a chunk, or carries end of stream, the block stops taking
// requests and shifts the cell chain towards cell 0, one response per cycle
// while the receiver is ready, for as many responses as there are active
// channels; zeros enter at the far end so the chain is clear when the burst
// ends. The request side is held until the last response of the burst is
// taken. A write to either register clears the accumulators and the frame
// and channel positions.
module multichannel_minmax_decimator_top
   import mmd_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCH_BITS = CH_BITS + 1;
   localparam int CMP_BITS = 8;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CHAN_CNT_BITS-1:0] chan_cnt_ff, chan_cnt_in;
   logic [CHUNK_BITS-1:0]    chunk_ff, chunk_in;
   logic [CH_BITS-1:0]       ch_ff, ch_in;
   logic [CHUNK_BITS-1:0]    frame_ff, frame_in;
   logic [CH_BITS-1:0]       out_ff, out_in;

   logic [CMP_BITS-1:0]      cnt_wide;
   logic [NCH_BITS-1:0]      nch;
   logic [CHUNK_BITS-1:0]    chunk_eff;
   logic [CH_BITS-1:0]       ch_eff;
   logic [NCH_BITS-1:0]      ch_next;
   logic [CHUNK_BITS-1:0]    frame_next;
   logic                     frame_done;
   logic                     req_take;
   logic                     rsp_take;
   logic                     is_last;
   logic                     csr_hit;
   logic                     emit;
   cell_ctrl_type            ctrl;
   logic [MAX_CHANNELS-1:0]  sel;

   logic signed [SAMPLE_BITS-1:0] cell_min [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] cell_max [MAX_CHANNELS];

   // Effective channel count and chunk length
   always_comb begin
      cnt_wide = CMP_BITS'(chan_cnt_ff);
      if (cnt_wide == '0) begin
         nch = NCH_BITS'(1);
      end else if (cnt_wide > CMP_BITS'(MAX_CHANNELS)) begin
         nch = NCH_BITS'(MAX_CHANNELS);
      end else begin
         nch = NCH_BITS'(cnt_wide);
      end
      chunk_eff = (chunk_ff == '0) ? CHUNK_BITS'(1) : chunk_ff;
   end

   // Channel and frame position of the incoming request
   always_comb begin
      ch_eff     = (NCH_BITS'(ch_ff) >= nch) ? '0 : ch_ff;
      ch_next    = NCH_BITS'(ch_eff) + NCH_BITS'(1);
      frame_done = (ch_next >= nch);
      frame_next = frame_ff + CHUNK_BITS'(1);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_FLUSH);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign is_last   = (NCH_BITS'(out_ff) + NCH_BITS'(1) == nch);
   assign csr_hit   = csr_we && ((csr_index == REG_CHANNEL_COUNT) ||
                                 (csr_index == REG_CHUNK_FRAMES));
   assign emit      = req_take &&
                      (req_data.end_of_stream || (frame_done && (frame_next >= chunk_eff)));

   // Cell commands
   always_comb begin
      ctrl.clear  = csr_hit;
      ctrl.shift  = rsp_take;
      ctrl.update = req_take;
   end

   // Select the cell of the current channel
   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         sel[i] = (ch_eff == CH_BITS'(i));
      end
   end

   // Positions, registers and burst sequencing
   always_comb begin
      state_in    = state_ff;
      chan_cnt_in = chan_cnt_ff;
      chunk_in    = chunk_ff;
      ch_in       = ch_ff;
      frame_in    = frame_ff;
      out_in      = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_hit) begin
               if (csr_index == REG_CHANNEL_COUNT) begin
                  chan_cnt_in = csr_wdata[CHAN_CNT_BITS-1:0];
               end else begin
                  chunk_in = csr_wdata[CHUNK_BITS-1:0];
               end
               ch_in    = '0;
               frame_in = '0;
            end else if (req_take) begin
               if (frame_done) begin
                  ch_in    = '0;
                  frame_in = frame_next;
               end else begin
                  ch_in = ch_next[CH_BITS-1:0];
               end
               if (emit) begin
                  ch_in    = '0;
                  frame_in = '0;
                  out_in   = '0;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (rsp_take) begin
               // advance through the chain; drop back to idle after the last
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  out_in = out_ff + CH_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chan_cnt_ff <= CHAN_CNT_RESET;
         chunk_ff    <= CHUNK_RESET;
         ch_ff       <= '0;
         frame_ff    <= '0;
         out_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         chan_cnt_ff <= chan_cnt_in;
         chunk_ff    <= chunk_in;
         ch_ff       <= ch_in;
         frame_ff    <= frame_in;
         out_ff      <= out_in;
      end
   end

   // Chain of accumulator cells; zeros enter at the far end
   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] nb_min;
      logic signed [SAMPLE_BITS-1:0] nb_max;
      if (g == MAX_CHANNELS - 1) begin : g_end
         assign nb_min = '0;
         assign nb_max = '0;
      end else begin : g_mid
         assign nb_min = cell_min[g+1];
         assign nb_max = cell_max[g+1];
      end
      mmd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sel        (sel[g]),
         .value_low  (req_data.value_low),
         .value_high (req_data.value_high),
         .next_min   (nb_min),
         .next_max   (nb_max),
         .cur_min    (cell_min[g]),
         .cur_max    (cell_max[g])
      );
   end

   // Response comes from the head of the chain
   always_comb begin
      rsp_data.channel      = CHAN_FIELD_BITS'(out_ff);
      rsp_data.peak_min     = cell_min[0];
      rsp_data.peak_max     = cell_max[0];
      rsp_data.last_channel = is_last;
   end

endmodule

// File: test/mmd_peak_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multichannel min/max peak decimator: watches the request,
// response and register ports, predicts each peak burst and compares in order.
// Depends on mmd_pkg.
module mmd_peak_checker
   import mmd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatch_count,
   output int                        pending_peaks
);

   localparam int CHANNEL_SLOTS = MAX_CHANNELS_DEF;
   localparam int REPORT_LIMIT  = 10;

   // Shadow of the register file and the running extremes
   logic [CHAN_CNT_BITS-1:0]      cfg_channels = CHAN_CNT_RESET;
   logic [CHUNK_BITS-1:0]         cfg_chunk    = CHUNK_RESET;
   logic signed [SAMPLE_BITS-1:0] run_min [CHANNEL_SLOTS];
   logic signed [SAMPLE_BITS-1:0] run_max [CHANNEL_SLOTS];
   int                            chan_pos     = 0;
   logic [CHUNK_BITS-1:0]         frame_pos    = '0;
   rsp_type                       peak_queue [$];
   int                            bad_peaks    = 0;
   int                            queue_depth  = 0;

   assign mismatch_count = bad_peaks;
   assign pending_peaks  = queue_depth;

   // Zero means one channel; anything past the slot count saturates
   function automatic int active_channels();
      int n;
      n = cfg_channels;
      if (n == 0) n = 1;
      if (n > CHANNEL_SLOTS) n = CHANNEL_SLOTS;
      return n;
   endfunction

   task automatic clear_run();
      for (int k = 0; k < CHANNEL_SLOTS; k++) begin
         run_min[k] = '0;
         run_max[k] = '0;
      end
      chan_pos  = 0;
      frame_pos = '0;
   endtask

   // Fold one request into its channel and queue a burst when the chunk closes
   task automatic fold_sample(input req_type r);
      int                    nch;
      int                    ch;
      logic [CHUNK_BITS-1:0] chunk;
      bit                    flush;
      rsp_type               pk;
      nch   = active_channels();
      chunk = (cfg_chunk == '0) ? CHUNK_BITS'(1) : cfg_chunk;
      ch    = (chan_pos >= nch) ? 0 : chan_pos;
      flush = r.end_of_stream;
      if (r.value_high > run_max[ch]) run_max[ch] = r.value_high;
      if (r.value_low < run_min[ch]) run_min[ch] = r.value_low;
      if (ch + 1 >= nch) begin
         chan_pos  = 0;
         frame_pos = frame_pos + 1'b1;
         if (frame_pos >= chunk) flush = 1'b1;
      end else begin
         chan_pos = ch + 1;
      end
      if (flush) begin
         for (int k = 0; k < nch; k++) begin
            pk.channel      = k[CHAN_FIELD_BITS-1:0];
            pk.peak_min     = run_min[k];
            pk.peak_max     = run_max[k];
            pk.last_channel = (k == nch - 1);
            peak_queue.push_back(pk);
         end
         clear_run();
      end
   endtask

   task automatic note_mismatch(input string msg);
      bad_peaks++;
      if (bad_peaks <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   // Compare one response against the oldest predicted peak
   task automatic check_peak(input rsp_type got);
      rsp_type want;
      if (peak_queue.size() == 0) begin
         note_mismatch($sformatf("unexpected peak: ch %0d min %0d max %0d last %0d",
            got.channel, got.peak_min, got.peak_max, got.last_channel));
      end else begin
         want = peak_queue.pop_front();
         if (got.channel !== want.channel || got.peak_min !== want.peak_min ||
             got.peak_max !== want.peak_max || got.last_channel !== want.last_channel)
            note_mismatch({
               $sformatf("peak mismatch: expected ch %0d min %0d max %0d last %0d",
                  want.channel, want.peak_min, want.peak_max, want.last_channel),
               $sformatf(", got ch %0d min %0d max %0d last %0d",
                  got.channel, got.peak_min, got.peak_max, got.last_channel)});
      end
   endtask

   initial clear_run();

   // Sample every port at the rising edge; responses first, as they are older
   always @(posedge clock) begin
      if (reset) begin
         cfg_channels = CHAN_CNT_RESET;
         cfg_chunk    = CHUNK_RESET;
         clear_run();
         peak_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CHANNEL_COUNT: begin
                  cfg_channels = csr_wdata[CHAN_CNT_BITS-1:0];
                  clear_run();
               end
               REG_CHUNK_FRAMES: begin
                  cfg_chunk = csr_wdata[CHUNK_BITS-1:0];
                  clear_run();
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_peak(rsp_data);
         if (req_valid && req_ready) fold_sample(req_data);
      end
      queue_depth = peak_queue.size();
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the multichannel min/max peak decimator: clock, reset,
// stimulus with bursty requests and a stalling receiver, verdict and watchdog.
// Depends on mmd_pkg, multichannel_minmax_decimator_top and mmd_peak_checker.
module tb_top;
   import mmd_pkg::*;

   localparam int RANDOM_ITEMS   = 380;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int REQ_BITS       = $bits(req_type);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int                        mismatches;
   int                        pending;

   int          burst_left   = 0;
   int          stall_cycles = 0;
   int          rx_mode      = 0;
   int unsigned mode_left    = 0;
   logic [7:0]  rx_tick      = '0;

   multichannel_minmax_decimator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mmd_peak_checker peak_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_peaks  (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: switch between always ready, coin toss, mostly stalled and runs
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1'b1;
      if (mode_left == 0) begin
         rx_mode   <= $urandom_range(0, 3);
         mode_left <= $urandom_range(20, 150);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= rx_tick[3];
      endcase
   end

   // Watchdog: give up after a long run of cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic req_type make_item(input logic signed [SAMPLE_BITS-1:0] lo,
                                         input logic signed [SAMPLE_BITS-1:0] hi,
                                         input logic eos);
      req_type r;
      r.value_low     = lo;
      r.value_high    = hi;
      r.end_of_stream = eos;
      return r;
   endfunction

   // Lean on the extremes and on values around zero
   function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         4: return 16'sd1;
         default: return raw[SAMPLE_BITS-1:0];
      endcase
   endfunction

   // Mostly raw samples, some ordered peak records, a few with low above high
   function automatic req_type make_sample(input logic eos);
      logic signed [SAMPLE_BITS-1:0] a;
      logic signed [SAMPLE_BITS-1:0] b;
      logic signed [SAMPLE_BITS-1:0] t;
      int shape;
      a     = pick_value();
      b     = pick_value();
      shape = $urandom_range(0, 9);
      if (shape <= 5) begin
         b = a;
      end else if (shape <= 8 && a > b) begin
         t = a;
         a = b;
         b = t;
      end
      return make_item(a, b, eos);
   endfunction

   // Offer one request, hold it until taken, then maybe open a gap
   task automatic push_request(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 12);
         burst_left = $urandom_range(0, 40);
         req_valid <= 1'b0;
         req_data  <= REQ_BITS'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted peak has been seen
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Reprogram both registers on an idle block, in random order
   task automatic apply_config(input logic [CSR_DATA_BITS-1:0] count_word,
                               input logic [CSR_DATA_BITS-1:0] chunk_word);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'($urandom);
      settle();
      if ($urandom_range(0, 1)) begin
         write_reg(REG_CHANNEL_COUNT, count_word);
         write_reg(REG_CHUNK_FRAMES, chunk_word);
      end else begin
         write_reg(REG_CHUNK_FRAMES, chunk_word);
         write_reg(REG_CHANNEL_COUNT, count_word);
      end
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, junk);
      csr_we <= 1'b0;
   endtask

   initial begin
      int                       random_sent;
      int                       phase_len;
      int                       eos_odds;
      logic [CSR_DATA_BITS-1:0] count_word;
      logic [CSR_DATA_BITS-1:0] chunk_word;
      random_sent = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: two channels; low above high moves neither extreme,
      // then end of stream mid-frame flushes both channels
      push_request(make_item(16'sd32767, -16'sd32768, 1'b0));
      push_request(make_item(-16'sd32768, 16'sd32767, 1'b0));
      push_request(make_item(-16'sd1, 16'sd1, 1'b1));

      // Three channels, one-frame chunks; end of stream on a chunk boundary
      apply_config(16'd3, 16'd1);
      push_request(make_item(-16'sd5, 16'sd7, 1'b0));
      push_request(make_item(16'sd3, 16'sd4, 1'b0));
      push_request(make_item(16'sd0, 16'sd0, 1'b0));
      push_request(make_item(-16'sd32768, -16'sd32768, 1'b0));
      push_request(make_item(16'sd32767, 16'sd32767, 1'b0));
      push_request(make_item(-16'sd2, 16'sd9, 1'b1));

      // Zero channel count and zero chunk length both act as one
      apply_config(16'd0, 16'd0);
      push_request(make_item(-16'sd100, 16'sd200, 1'b0));
      push_request(make_item(16'sd50, -16'sd50, 1'b0));

      // Channel count saturates at the slot count; longest chunk, flushed early
      apply_config(16'hFFFF, 16'hFFFF);
      for (int k = 0; k < 9; k++)
         push_request(make_sample(1'b0));
      push_request(make_sample(1'b1));

      // Random phases, each under a fresh register setting
      while (random_sent < RANDOM_ITEMS) begin
         count_word = CSR_DATA_BITS'($urandom);
         count_word[CHAN_CNT_BITS-1:0] = CHAN_CNT_BITS'($urandom_range(0, 15));
         case ($urandom_range(0, 7))
            0: chunk_word = 16'd0;
            1: chunk_word = 16'hFFFF;
            2: chunk_word = CSR_DATA_BITS'($urandom);
            default: chunk_word = CSR_DATA_BITS'($urandom_range(1, 6));
         endcase
         eos_odds  = (chunk_word > 16) ? 10 : 40;
         phase_len = $urandom_range(20, 50);
         apply_config(count_word, chunk_word);
         for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
            push_request(make_sample($urandom_range(0, eos_odds - 1) == 0));
            random_sent++;
            if ($urandom_range(0, 39) == 0) settle();
         end
      end

      settle();
      if (mismatches == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
